@@ src/u2af_pkg.sv @@
// Shared types, constants and the Latin-1 fold table of the UTF-8 to ASCII fold filter.
package u2af_pkg;

  localparam int unsigned TitleLenDefault = 64;

  localparam logic [7:0] LeadMin   = 8'hC2;
  localparam logic [7:0] LeadMax   = 8'hF4;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [1:0] ContTag   = 2'b10;
  localparam logic [6:0] AsciiMin  = 7'h20;
  localparam logic [6:0] AsciiMax  = 7'h7E;
  localparam logic [6:0] SpaceChar = 7'h20;
  localparam logic [6:0] NulChar   = 7'h00;
  localparam int unsigned CpW      = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       char_valid;
    logic       end_of_text;
  } out_t;

  // Base letter of U+00C0 + idx, or zero where there is none.
  function automatic logic [6:0] latin_base_letter(input logic [5:0] idx);
    logic [6:0] base;
    base = NulChar;
    case (idx[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5:        base = 7'h41; // A
      5'd7:                                      base = 7'h43; // C
      5'd8, 5'd9, 5'd10, 5'd11:                  base = 7'h45; // E
      5'd12, 5'd13, 5'd14, 5'd15:                base = 7'h49; // I
      5'd17:                                     base = 7'h4E; // N
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22:         base = 7'h4F; // O
      5'd25, 5'd26, 5'd27, 5'd28:                base = 7'h55; // U
      5'd29:                                     base = 7'h59; // Y
      default:                                   base = NulChar;
    endcase
    if (idx == 6'd63) begin
      return 7'h79; // y with diaeresis
    end
    if (idx[5] && base != NulChar) begin
      return base | 7'h20;
    end
    return base;
  endfunction

endpackage

@@ src/utf8_to_ascii_fold_filter.sv @@
// Top level of the UTF-8 to ASCII fold filter: decoder, fold, space collapse and result queue.
//
// Usage: raw UTF-8 bytes enter on the in channel (in_valid_i / in_ready_o, payload in_i),
// in_i.in_last marking the final byte of a text. ASCII characters leave on the out channel
// (out_valid_o / out_ready_i, payload out_o), one per beat; a beat with end_of_text set and
// char_valid clear closes each text. One input byte causes zero to three output beats
// (a collapsed space, a character, a terminator).
// Order: a byte is held in the input register, then decoded and written to a four-entry
// result queue, from which its first result is presented.
// Throughput: one byte per cycle while the queue holds at most one result; while the
// receiver is ready the output drains one result per cycle, so bytes that cause two or
// three results slow the input to the output rate.
// Reset clears the decode state, the character count and the queue; the next byte starts
// a new text. When the receiver stalls, results stay queued, and the input stops once
// the queue could not hold the results of another byte.
module utf8_to_ascii_fold_filter #(
  parameter int unsigned TITLE_LEN = u2af_pkg::TitleLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  u2af_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output u2af_pkg::out_t out_o
);

  localparam int unsigned CntW = (TITLE_LEN > 2) ? $clog2(TITLE_LEN) : 1;
  localparam logic [CntW-1:0] CntLimit = CntW'(TITLE_LEN - 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = QPtrW + 1;
  localparam logic [QCntW-1:0] QRoomMax = QCntW'(QDepth - 3);

  // Input register
  logic          stg_v_q, stg_v_d;
  u2af_pkg::in_t stg_q;

  // Decode state
  logic [1:0]                   bp_q, bp_d;
  logic [u2af_pkg::CpW-1:0]     pcp_q, pcp_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         sp_q, sp_d;
  logic                         any_q, any_d;
  logic                         done_q, done_d;

  // Result queue
  u2af_pkg::out_t   q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] qcnt_q, qcnt_d;

  logic room, fire, pop;
  logic [7:0] b;
  logic is_cont, take_cp;
  logic [u2af_pkg::CpW-1:0] cp;
  logic [6:0] ch;
  logic emit_sp, emit_ch, emit_t;
  logic [1:0] push_n;
  u2af_pkg::out_t res [3];

  assign room       = qcnt_q <= QRoomMax;
  assign fire       = stg_v_q && room;
  assign in_ready_o = !stg_v_q || room;
  assign pop        = out_valid_o && out_ready_i;
  assign b          = stg_q.in_byte;

  always_comb begin
    stg_v_d = stg_v_q;
    if (in_valid_i && in_ready_o) begin
      stg_v_d = 1'b1;
    end else if (fire) begin
      stg_v_d = 1'b0;
    end
  end

  always_comb begin
    bp_d    = bp_q;
    pcp_d   = pcp_q;
    cnt_d   = cnt_q;
    sp_d    = sp_q;
    any_d   = any_q;
    done_d  = done_q;
    take_cp = 1'b0;
    cp      = '0;
    ch      = u2af_pkg::NulChar;
    emit_sp = 1'b0;
    emit_ch = 1'b0;
    emit_t  = 1'b0;
    is_cont = (bp_q != 2'd0) && (b[7:6] == u2af_pkg::ContTag);

    if (!done_q) begin
      if (b == 8'h00) begin
        emit_t = 1'b1;
        done_d = 1'b1;
        bp_d   = 2'd0;
        pcp_d  = '0;
      end else if (is_cont) begin
        pcp_d = {pcp_q[u2af_pkg::CpW-7:0], b[5:0]};
        bp_d  = bp_q - 2'd1;
        if (bp_q == 2'd1) begin
          take_cp = 1'b1;
          cp      = pcp_d;
        end
      end else begin
        // A bad continuation drops the partial sequence; decode the byte as a lead.
        bp_d  = 2'd0;
        pcp_d = '0;
        if (!b[7]) begin
          take_cp = 1'b1;
          cp      = {{(u2af_pkg::CpW-8){1'b0}}, b};
        end else if (b >= u2af_pkg::LeadMin && b <= u2af_pkg::LeadMax) begin
          if (b < u2af_pkg::Lead3Min) begin
            bp_d  = 2'd1;
            pcp_d = {{(u2af_pkg::CpW-5){1'b0}}, b[4:0]};
          end else if (b < u2af_pkg::Lead4Min) begin
            bp_d  = 2'd2;
            pcp_d = {{(u2af_pkg::CpW-4){1'b0}}, b[3:0]};
          end else begin
            bp_d  = 2'd3;
            pcp_d = {{(u2af_pkg::CpW-3){1'b0}}, b[2:0]};
          end
        end
      end

      if (take_cp && cnt_q != CntLimit) begin
        if (cp[u2af_pkg::CpW-1:7] == '0 && cp[6:0] >= u2af_pkg::AsciiMin
            && cp[6:0] <= u2af_pkg::AsciiMax) begin
          ch = cp[6:0];
        end else if (cp[u2af_pkg::CpW-1:6] == (u2af_pkg::CpW-6)'(3)) begin
          ch = u2af_pkg::latin_base_letter(cp[5:0]);
        end
        if (ch != u2af_pkg::NulChar) begin
          cnt_d = cnt_q + CntW'(1);
          if (ch == u2af_pkg::SpaceChar) begin
            if (any_q) begin
              sp_d = 1'b1;
            end
          end else begin
            emit_sp = sp_q;
            emit_ch = 1'b1;
            sp_d    = 1'b0;
            any_d   = 1'b1;
          end
        end
      end

      if (stg_q.in_last) begin
        emit_t = 1'b1;
      end
    end

    // Last byte: return the decode state and character count to reset.
    if (stg_q.in_last) begin
      bp_d   = 2'd0;
      pcp_d  = '0;
      cnt_d  = '0;
      sp_d   = 1'b0;
      any_d  = 1'b0;
      done_d = 1'b0;
    end
  end

  // Pack results in output order: space, character, terminator.
  always_comb begin
    u2af_pkg::out_t r_sp, r_ch, r_t;
    r_sp = '{out_char: u2af_pkg::SpaceChar, char_valid: 1'b1, end_of_text: 1'b0};
    r_ch = '{out_char: ch, char_valid: 1'b1, end_of_text: 1'b0};
    r_t  = '{out_char: u2af_pkg::NulChar, char_valid: 1'b0, end_of_text: 1'b1};
    res[0] = emit_sp ? r_sp : (emit_ch ? r_ch : r_t);
    res[1] = (emit_sp && emit_ch) ? r_ch : r_t;
    res[2] = r_t;
    push_n = fire ? (2'(emit_sp) + 2'(emit_ch) + 2'(emit_t)) : 2'd0;
  end

  assign wr_d   = wr_q + QPtrW'(push_n);
  assign rd_d   = pop ? rd_q + QPtrW'(1) : rd_q;
  assign qcnt_d = qcnt_q + QCntW'(push_n) - QCntW'(pop);

  assign out_valid_o = qcnt_q != '0;
  assign out_o       = q_mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      bp_q    <= 2'd0;
      pcp_q   <= '0;
      cnt_q   <= '0;
      sp_q    <= 1'b0;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
      wr_q    <= '0;
      rd_q    <= '0;
      qcnt_q  <= '0;
    end else begin
      stg_v_q <= stg_v_d;
      if (fire) begin
        bp_q   <= bp_d;
        pcp_q  <= pcp_d;
        cnt_q  <= cnt_d;
        sp_q   <= sp_d;
        any_q  <= any_d;
        done_q <= done_d;
      end
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_i;
    end
  end

  // Write each queue slot from the packed result at its offset past the write pointer.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QDepth; k++) begin
      logic [QPtrW-1:0] off;
      off = QPtrW'(k) - wr_q;
      if ({1'b0, off} < {1'b0, push_n}) begin
        q_mem_q[k] <= res[off[1:0]];
      end
    end
  end

endmodule
